@@ hdl/kabf_pkg.sv @@
// Shared constants and types of the angle/bias Kalman filter.
package kabf_pkg;

    localparam int DATA_WIDTH_DEF = 48;
    localparam int FIELD_W        = 48;
    localparam int CFG_W          = 32;
    localparam int DT_W           = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int FRAC_BITS      = 32;
    localparam int DT_FRAC        = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Q = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Q  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_R  = 2'd2;

    localparam logic [CFG_W-1:0] ANGLE_Q_RST = 32'd4294967;
    localparam logic [CFG_W-1:0] BIAS_Q_RST  = 32'd12884902;
    localparam logic [CFG_W-1:0] MEAS_R_RST  = 32'd128849019;

    typedef struct packed {
        logic start;
        logic frac32;
    } unit_ctl_t;

endpackage

@@ hdl/kabf_ifs.sv @@
// Channel interfaces: input samples, results and configuration writes.
interface kabf_in_if
    import kabf_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] measured_angle;
    logic signed [FIELD_W-1:0] measured_rate;
    logic        [DT_W-1:0]    time_step;

    modport source (output valid, measured_angle, measured_rate, time_step, input ready);
    modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface kabf_out_if
    import kabf_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] estimated_angle;
    logic signed [FIELD_W-1:0] estimated_bias;

    modport source (output valid, estimated_angle, estimated_bias, input ready);
    modport sink   (input valid, estimated_angle, estimated_bias, output ready);
endinterface

interface kabf_cfg_if
    import kabf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/kalman_angle_bias_filter_core.sv @@
// Top level: sequencer, operand memory and ALU of the angle/bias Kalman filter.
//
//  channel  dir  word
//  sample   in   measured_angle, measured_rate, time_step
//  result   out  estimated_angle, estimated_bias
//  cfg      in   index, data (noise registers)
//
// One sample goes through accept, loads of the measured angle, the measured rate
// and the three noise values, 29 micro-ops in order and the result step. Add/sub
// ops write back from ST_EXEC; the ten bit-serial multiplies and the two bit-serial
// divides write back from ST_WAIT. One sample is in work at a time; the next is
// taken while a result waits in the output register. No clearing pass after reset:
// state entries read zero until written. cfg is always ready.
module kalman_angle_bias_filter_core
    import kabf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    kabf_in_if.sink    sample,
    kabf_out_if.source result,
    kabf_cfg_if.sink   cfg
);

    localparam int W     = DATA_WIDTH;
    localparam int XW    = ((W > FIELD_W) ? W : FIELD_W) + 1;
    localparam int CW    = ((W > CFG_W) ? W : CFG_W) + 1;
    localparam int DEPTH = 19;
    localparam logic [4:0] LAST_PC = 5'd28;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [4:0] {
        A_ANG, A_BIAS, A_P0, A_P1, A_P2, A_P3, A_RATE, A_DP, A_T, A_S,
        A_K0, A_K1, A_Y, A_PROD, A_MEAS, A_RIN, A_QA, A_QB, A_RM
    } addr_t;

    typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL24, OP_MUL32, OP_DIV} op_t;

    typedef struct packed {
        op_t   op;
        addr_t dst;
        addr_t a;
        addr_t b;
    } instr_t;

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_FETCH, ST_EXEC, ST_WAIT, ST_DONE} state_t;

    function automatic instr_t prog(input logic [4:0] pc);
        instr_t i;
        case (pc)
            5'd0:    i = '{OP_SUB,   A_RATE, A_RIN,  A_BIAS};
            5'd1:    i = '{OP_MUL24, A_PROD, A_RATE, A_RATE};
            5'd2:    i = '{OP_ADD,   A_ANG,  A_ANG,  A_PROD};
            5'd3:    i = '{OP_MUL24, A_DP,   A_P3,   A_P3};
            5'd4:    i = '{OP_SUB,   A_T,    A_DP,   A_P1};
            5'd5:    i = '{OP_SUB,   A_T,    A_T,    A_P2};
            5'd6:    i = '{OP_ADD,   A_T,    A_T,    A_QA};
            5'd7:    i = '{OP_MUL24, A_PROD, A_T,    A_T};
            5'd8:    i = '{OP_ADD,   A_P0,   A_P0,   A_PROD};
            5'd9:    i = '{OP_SUB,   A_P1,   A_P1,   A_DP};
            5'd10:   i = '{OP_SUB,   A_P2,   A_P2,   A_DP};
            5'd11:   i = '{OP_MUL24, A_PROD, A_QB,   A_QB};
            5'd12:   i = '{OP_ADD,   A_P3,   A_P3,   A_PROD};
            5'd13:   i = '{OP_ADD,   A_S,    A_P0,   A_RM};
            5'd14:   i = '{OP_DIV,   A_K0,   A_P0,   A_S};
            5'd15:   i = '{OP_DIV,   A_K1,   A_P2,   A_S};
            5'd16:   i = '{OP_SUB,   A_Y,    A_MEAS, A_ANG};
            5'd17:   i = '{OP_MUL32, A_PROD, A_K0,   A_Y};
            5'd18:   i = '{OP_ADD,   A_ANG,  A_ANG,  A_PROD};
            5'd19:   i = '{OP_MUL32, A_PROD, A_K1,   A_Y};
            5'd20:   i = '{OP_ADD,   A_BIAS, A_BIAS, A_PROD};
            5'd21:   i = '{OP_MUL32, A_PROD, A_K1,   A_P0};
            5'd22:   i = '{OP_SUB,   A_P2,   A_P2,   A_PROD};
            5'd23:   i = '{OP_MUL32, A_PROD, A_K0,   A_P0};
            5'd24:   i = '{OP_SUB,   A_P0,   A_P0,   A_PROD};
            5'd25:   i = '{OP_MUL32, A_PROD, A_K1,   A_P1};
            5'd26:   i = '{OP_SUB,   A_P3,   A_P3,   A_PROD};
            5'd27:   i = '{OP_MUL32, A_PROD, A_K0,   A_P1};
            5'd28:   i = '{OP_SUB,   A_P1,   A_P1,   A_PROD};
            default: i = '{OP_ADD,   A_PROD, A_PROD, A_PROD};
        endcase
        return i;
    endfunction

    function automatic logic [W-1:0] clamp_field(input logic [FIELD_W-1:0] f);
        logic signed [XW-1:0] ext, hi, lo;
        ext = {{(XW-FIELD_W){f[FIELD_W-1]}}, f};
        hi  = {{(XW-W){1'b0}}, MAXV};
        lo  = {{(XW-W){1'b1}}, MINV};
        if (ext > hi)
            return MAXV;
        else if (ext < lo)
            return MINV;
        return ext[W-1:0];
    endfunction

    function automatic logic [W-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
        logic [CW-1:0] ext, hi;
        ext = {{(CW-CFG_W){1'b0}}, v};
        hi  = {{(CW-W){1'b0}}, MAXV};
        if (ext > hi)
            return MAXV;
        return ext[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_w(input logic [W:0] v);
        if (v[W] != v[W-1])
            return v[W] ? MINV : MAXV;
        return v[W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [W-1:0] v);
        logic [XW-1:0] ext;
        ext = {{(XW-W){v[W-1]}}, v};
        return ext[FIELD_W-1:0];
    endfunction

    state_t           state_reg;
    logic [4:0]       pc_reg;
    logic [2:0]       ld_cnt_reg;
    logic [W-1:0]     meas_reg, rin_reg;
    logic [DT_W-1:0]  dt_reg;
    logic [CFG_W-1:0] qa_cfg_reg, qb_cfg_reg, rm_cfg_reg;
    logic             out_valid_reg;
    logic [W-1:0]     ang_cur_reg, bias_cur_reg, out_ang_reg, out_bias_reg;

    logic [W-1:0]     mem [DEPTH];
    logic [DEPTH-1:0] mem_valid_reg;
    logic [W-1:0]     rd_a_reg, rd_b_reg;

    instr_t       ins;
    logic         wr_en;
    addr_t        wr_addr;
    logic [W-1:0] wr_data, alu_res, unit_res;
    logic [W:0]   alu_a, alu_b, mul_b;
    unit_ctl_t    mul_ctl, div_ctl;
    logic         mul_done, div_done, unit_done, op_done;
    logic [W-1:0] mul_res, div_res;

    assign ins = prog(pc_reg);

    always_comb
    begin
        alu_a   = {rd_a_reg[W-1], rd_a_reg};
        alu_b   = {rd_b_reg[W-1], rd_b_reg};
        alu_res = sat_w((ins.op == OP_SUB) ? (alu_a - alu_b) : (alu_a + alu_b));
        mul_b   = (ins.op == OP_MUL32) ? alu_b : {{(W+1-DT_W){1'b0}}, dt_reg};

        mul_ctl.start  = (state_reg == ST_EXEC) &&
                         ((ins.op == OP_MUL24) || (ins.op == OP_MUL32));
        mul_ctl.frac32 = (ins.op == OP_MUL32);
        div_ctl.start  = (state_reg == ST_EXEC) && (ins.op == OP_DIV);
        div_ctl.frac32 = 1'b1;

        unit_done = mul_done || div_done;
        unit_res  = (ins.op == OP_DIV) ? div_res : mul_res;

        wr_en   = 1'b0;
        wr_addr = ins.dst;
        wr_data = alu_res;
        op_done = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                wr_en = 1'b1;
                case (ld_cnt_reg)
                    3'd0:    begin wr_addr = A_MEAS; wr_data = meas_reg; end
                    3'd1:    begin wr_addr = A_RIN;  wr_data = rin_reg; end
                    3'd2:    begin wr_addr = A_QA;   wr_data = clamp_cfg(qa_cfg_reg); end
                    3'd3:    begin wr_addr = A_QB;   wr_data = clamp_cfg(qb_cfg_reg); end
                    default: begin wr_addr = A_RM;   wr_data = clamp_cfg(rm_cfg_reg); end
                endcase
            end
            ST_EXEC:
            begin
                if ((ins.op == OP_ADD) || (ins.op == OP_SUB))
                begin
                    wr_en   = 1'b1;
                    op_done = 1'b1;
                end
            end
            ST_WAIT:
            begin
                wr_en   = unit_done;
                wr_data = unit_res;
                op_done = unit_done;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem_valid_reg[ins.a] ? mem[ins.a] : '0;
        rd_b_reg <= mem_valid_reg[ins.b] ? mem[ins.b] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mem_valid_reg <= '0;
        else if (wr_en)
            mem_valid_reg[wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            ld_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            qa_cfg_reg    <= ANGLE_Q_RST;
            qb_cfg_reg    <= BIAS_Q_RST;
            rm_cfg_reg    <= MEAS_R_RST;
            ang_cur_reg   <= '0;
            bias_cur_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_ANGLE_Q: qa_cfg_reg <= cfg.data;
                    CFG_BIAS_Q:  qb_cfg_reg <= cfg.data;
                    CFG_MEAS_R:  rm_cfg_reg <= cfg.data;
                    default:     qa_cfg_reg <= qa_cfg_reg;
                endcase
            end

            if ((state_reg == ST_DONE) && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (wr_en && (wr_addr == A_ANG))
                ang_cur_reg <= wr_data;
            if (wr_en && (wr_addr == A_BIAS))
                bias_cur_reg <= wr_data;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        meas_reg   <= clamp_field(sample.measured_angle);
                        rin_reg    <= clamp_field(sample.measured_rate);
                        dt_reg     <= sample.time_step;
                        ld_cnt_reg <= '0;
                        state_reg  <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    ld_cnt_reg <= ld_cnt_reg + 1'b1;
                    if (ld_cnt_reg == 3'd4)
                    begin
                        pc_reg    <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC, ST_WAIT:
                begin
                    if (op_done)
                    begin
                        if (pc_reg == LAST_PC)
                            state_reg <= ST_DONE;
                        else
                        begin
                            pc_reg    <= pc_reg + 1'b1;
                            state_reg <= ST_FETCH;
                        end
                    end
                    else if (state_reg == ST_EXEC)
                        state_reg <= ST_WAIT;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_ang_reg   <= ang_cur_reg;
                        out_bias_reg  <= bias_cur_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    kabf_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (alu_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_res)
    );

    kabf_div #(.W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .n     (rd_a_reg),
        .d     (rd_b_reg),
        .done  (div_done),
        .quot  (div_res)
    );

    assign sample.ready           = (state_reg == ST_IDLE);
    assign cfg.ready              = 1'b1;
    assign result.valid           = out_valid_reg;
    assign result.estimated_angle = to_field(out_ang_reg);
    assign result.estimated_bias  = to_field(out_bias_reg);

endmodule

@@ hdl/kabf_mul.sv @@
// Bit-serial shift-add multiplier with rounding and saturation.
module kabf_mul
    import kabf_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  unit_ctl_t        ctl,
    input  logic signed [W:0] a,
    input  logic signed [W:0] b,
    output logic             done,
    output logic [W-1:0]     prod
);

    localparam int CNT_W = $clog2(W);
    localparam logic [2*W:0] HALF32 = (2*W+1)'(1) << (FRAC_BITS - 1);
    localparam logic [2*W:0] HALF24 = (2*W+1)'(1) << (DT_FRAC - 1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic             busy_reg, fin_reg, done_reg, neg_reg, frac32_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     mcand_reg, lo_reg, prod_reg;
    logic [W:0]       hi_reg;

    logic [W:0]     a_abs, b_abs, sum;
    logic [2*W:0]   rnd, shd;
    logic           ovf;
    logic [W-1:0]   mag, res;

    always_comb
    begin
        a_abs = a[W] ? (W+1)'(-a) : a;
        b_abs = b[W] ? (W+1)'(-b) : b;
        sum   = hi_reg + {1'b0, (lo_reg[0] ? mcand_reg : '0)};
        rnd   = {1'b0, hi_reg[W-1:0], lo_reg} + (frac32_reg ? HALF32 : HALF24);
        shd   = frac32_reg ? (rnd >> FRAC_BITS) : (rnd >> DT_FRAC);
        ovf   = |shd[2*W:W-1];
        mag   = shd[W-1:0];
        if (ovf)
            res = neg_reg ? MINV : MAXV;
        else
            res = neg_reg ? W'(-mag) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                mcand_reg  <= a_abs[W-1:0];
                lo_reg     <= b_abs[W-1:0];
                hi_reg     <= '0;
                neg_reg    <= a[W] ^ b[W];
                frac32_reg <= ctl.frac32;
            end
            else if (busy_reg)
            begin
                hi_reg  <= {1'b0, sum[W:1]};
                lo_reg  <= {sum[0], lo_reg[W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                prod_reg <= res;
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ hdl/kabf_div.sv @@
// Bit-serial restoring divider: n * 2^32 / d, rounded and saturated.
module kabf_div
    import kabf_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  unit_ctl_t           ctl,
    input  logic signed [W-1:0] n,
    input  logic signed [W-1:0] d,
    output logic                done,
    output logic [W-1:0]        quot
);

    localparam int NB    = W + FRAC_BITS;
    localparam int CNT_W = $clog2(NB);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic             busy_reg, fin_reg, done_reg, neg_reg, zero_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NB-1:0]    num_reg, q_reg;
    logic [W:0]       rem_reg;
    logic [W-1:0]     dm_reg, quot_reg;

    logic [W-1:0] n_abs, d_abs, mag, res;
    logic [W:0]   rs;
    logic         ge, rup, ovf;
    logic [NB:0]  qr;

    always_comb
    begin
        n_abs = n[W-1] ? W'(-n) : n;
        d_abs = d[W-1] ? W'(-d) : d;
        rs    = {rem_reg[W-1:0], num_reg[NB-1]};
        ge    = rs >= {1'b0, dm_reg};
        rup   = {rem_reg, 1'b0} >= {2'b00, dm_reg};
        qr    = {1'b0, q_reg} + (NB+1)'(rup);
        ovf   = |qr[NB:W-1];
        mag   = qr[W-1:0];
        if (zero_reg)
            res = '0;
        else if (ovf)
            res = neg_reg ? MINV : MAXV;
        else
            res = neg_reg ? W'(-mag) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= {n_abs, {FRAC_BITS{1'b0}}};
                q_reg    <= '0;
                rem_reg  <= '0;
                dm_reg   <= d_abs;
                neg_reg  <= n[W-1] ^ d[W-1];
                zero_reg <= (d == '0);
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[NB-2:0], 1'b0};
                q_reg   <= {q_reg[NB-2:0], ge};
                rem_reg <= ge ? (rs - {1'b0, dm_reg}) : rs;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NB - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                quot_reg <= res;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ hdl/kabf_checker.sv @@
// Port-level checks of the filter core and their bind.
module kabf_checker
    import kabf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_valid,
    input logic               s_ready,
    input logic               r_valid,
    input logic               r_ready,
    input logic [FIELD_W-1:0] r_angle,
    input logic [FIELD_W-1:0] r_bias
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result word dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> $stable(r_angle) && $stable(r_bias))
        else $error("result word changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> !s_ready)
        else $error("sample taken while busy");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> !$rose(r_valid))
        else $error("result appeared without filter work");

endmodule

bind kalman_angle_bias_filter_core kabf_checker u_kabf_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample.valid),
    .s_ready (sample.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_angle (result.estimated_angle),
    .r_bias  (result.estimated_bias)
);
